// File: hdl/pal_pkg.sv
// Shared types and codes for the positional array list.
// Used by pal_ctrl, pal_dpath and positional_array_list; depends on nothing.
`default_nettype none

package pal_pkg;

   typedef enum logic [2:0] {
      OP_INS_POS   = 3'd0,
      OP_INS_FRONT = 3'd1,
      OP_INS_END   = 3'd2,
      OP_REM_POS   = 3'd3,
      OP_REM_FRONT = 3'd4,
      OP_REM_END   = 3'd5,
      OP_READ      = 3'd6,
      OP_WRITE     = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_HOLD = 1'b1
   } state_type;

   typedef struct packed {
      logic exec;
   } cmd_type;

   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

endpackage

`default_nettype wire

// File: hdl/pal_ctrl.sv
// Handshake controller for the positional array list.
// Uses pal_pkg; drives the execute command into pal_dpath.
`default_nettype none

module pal_ctrl
   import pal_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  wire     rsp_tready,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (rsp_tready && !req_tvalid) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
         end
         S_HOLD: begin
            req_tready = rsp_tready;
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      cmd.exec = req_tvalid && req_tready;
   end

`ifndef ASSERT_OFF
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_tvalid)
      else $error("accepted word produced no response");
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while response stalled");
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.exec))
      else $error("response raised without an accepted word");
`endif

endmodule

`default_nettype wire

// File: hdl/pal_dpath.sv
// Datapath of the positional array list: entry cells, count and response register.
// Uses pal_pkg; steered by the command from pal_ctrl.
`default_nettype none

module pal_dpath
   import pal_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  wire                       clock,
   input  wire                       reset,
   input  cmd_type                   cmd,
   input  op_type                    op,
   input  wire [POS_W-1:0]           position,
   input  wire signed [VALUE_W-1:0]  value,
   output logic signed [VALUE_W-1:0] data_out,
   output status_type                status,
   output logic [COUNT_W-1:0]        count,
   output logic                      is_empty
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int MW = (CW > POS_W) ? CW : POS_W;

   logic signed [VALUE_W-1:0] ent_ff [DEPTH];
   logic signed [VALUE_W-1:0] ent_in [DEPTH];
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;

   logic [MW-1:0]             pos_w;
   logic [MW-1:0]             cnt_w;
   logic [MW-1:0]             at_w;
   logic [MW-1:0]             cnt_next_w;
   logic                      do_ins;
   logic                      do_rem;
   logic                      do_wr;
   logic                      do_rd;
   status_type                st;
   logic signed [VALUE_W-1:0] rd_data;
   logic signed [VALUE_W-1:0] data_in;

   always_comb begin
      pos_w  = MW'(position);
      cnt_w  = MW'(count_ff);
      at_w   = '0;
      do_ins = 1'b0;
      do_rem = 1'b0;
      do_wr  = 1'b0;
      do_rd  = 1'b0;
      st     = ST_OK;
      case (op)
         OP_INS_POS, OP_INS_FRONT, OP_INS_END: begin
            if (op == OP_INS_POS) begin
               at_w = pos_w;
            end else if (op == OP_INS_END) begin
               at_w = cnt_w;
            end
            if (count_ff == CW'(DEPTH)) begin
               st = ST_FULL;
            end else if (at_w > cnt_w) begin
               st = ST_RANGE;
            end else begin
               do_ins = 1'b1;
            end
         end
         OP_REM_POS, OP_REM_FRONT, OP_REM_END: begin
            if (op == OP_REM_POS) begin
               at_w = pos_w;
            end else if (op == OP_REM_END) begin
               at_w = cnt_w - MW'(1);
            end
            if (count_ff == '0 || at_w >= cnt_w) begin
               st = ST_RANGE;
            end else begin
               do_rem = 1'b1;
            end
         end
         OP_READ: begin
            at_w = pos_w;
            if (at_w >= cnt_w) begin
               st = ST_RANGE;
            end else begin
               do_rd = 1'b1;
            end
         end
         default: begin
            at_w = pos_w;
            if (at_w >= cnt_w) begin
               st = ST_RANGE;
            end else begin
               do_wr = 1'b1;
            end
         end
      endcase
   end

   assign rd_data = ent_ff[at_w[IW-1:0]];
   assign data_in = (do_rd || do_rem) ? rd_data : '0;

   always_comb begin
      cnt_next_w = cnt_w;
      if (do_ins) begin
         cnt_next_w = cnt_w + MW'(1);
      end else if (do_rem) begin
         cnt_next_w = cnt_w - MW'(1);
      end
      count_in = count_ff;
      if (cmd.exec) begin
         count_in = cnt_next_w[CW-1:0];
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] lower;
      logic signed [VALUE_W-1:0] upper;

      if (i == 0) begin : g_first
         assign lower = ent_ff[i];
      end else begin : g_lower
         assign lower = ent_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign upper = ent_ff[i];
      end else begin : g_upper
         assign upper = ent_ff[i+1];
      end

      always_comb begin
         ent_in[i] = ent_ff[i];
         if (cmd.exec) begin
            if (do_ins) begin
               if (MW'(i) == at_w) begin
                  ent_in[i] = value;
               end else if (MW'(i) > at_w) begin
                  ent_in[i] = lower;
               end
            end else if (do_rem) begin
               if (MW'(i) >= at_w) begin
                  ent_in[i] = upper;
               end
            end else if (do_wr) begin
               if (MW'(i) == at_w) begin
                  ent_in[i] = value;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         ent_ff[i] <= ent_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         data_out <= data_in;
         status   <= st;
         count    <= cnt_next_w[COUNT_W-1:0];
         is_empty <= (cnt_next_w == '0);
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");
   a_fail_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && st != ST_OK) |=> count_ff == $past(count_ff))
      else $error("rejected request changed the count");
   a_ins_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && do_ins) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the count");
`endif

endmodule

`default_nettype wire

// File: hdl/positional_array_list.sv
// Positional array list: ordered store of signed 32-bit words with a count.
// Request word on req_*: op selects insert, remove, read or write at a position,
// the front or the end. One response word on rsp_* per request carries the
// removed or read value, a status (ok, full or out of range), the new
// count and an empty flag. Failed requests change nothing.
// The response is registered and valid the cycle after the request is accepted.
// Throughput: one request per cycle while rsp_tready stays high; every entry
// cell loads its neighbor in parallel, so the whole list shifts at once.
// The response register limits the rate when the receiver stalls:
// while a response waits with rsp_tready low, req_tready is low and the held
// response stays unchanged.
// Reset: synchronous, active high; clears the count and the response valid.
// Entry contents are not cleared and need no clearing pass, since only entries
// below the count are ever read.
// Uses pal_pkg, pal_ctrl and pal_dpath.
`default_nettype none

module positional_array_list
   import pal_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // position [4:0], value [36:5], zero [39:37]
   input  wire  [2:0]  req_tuser,   // op [2:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // data_out [31:0], count [36:32], zero [39:37]
   output logic [2:0]  rsp_tuser    // status [1:0], is_empty [2]
);

   cmd_type                   cmd;
   logic signed [VALUE_W-1:0] data_out;
   status_type                status;
   logic [COUNT_W-1:0]        count;
   logic                      is_empty;

   pal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   pal_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .op       (op_type'(req_tuser[2:0])),
      .position (req_tdata[4:0]),
      .value    (req_tdata[36:5]),
      .data_out (data_out),
      .status   (status),
      .count    (count),
      .is_empty (is_empty)
   );

   assign rsp_tdata = {3'b000, count, data_out};
   assign rsp_tuser = {is_empty, status};

endmodule

`default_nettype wire

// File: tb/positional_array_list_test.sv
// Self-checking testbench for positional_array_list: drives request words on req_*,
// predicts every response from a local copy of the list and checks rsp_* words.
// Depends on pal_pkg and the positional_array_list RTL.
`timescale 1ns / 1ps

module positional_array_list_test
   import pal_pkg::*;
();

   localparam int LIST_DEPTH  = 16;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [VALUE_W-1:0] data_out;
      status_type         status;
      logic [COUNT_W-1:0] count;
      logic               is_empty;
   } list_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // position [4:0], value [36:5], zero [39:37]
   logic [2:0]  req_tuser = '0;   // op [2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // data_out [31:0], count [36:32], zero [39:37]
   logic [2:0]  rsp_tuser;        // status [1:0], is_empty [2]

   logic [VALUE_W-1:0] list_store [LIST_DEPTH];
   logic [COUNT_W-1:0] list_count = '0;
   list_rsp_type       pending_rsps [$];
   int                 error_count = 0;
   int                 cycle_count = 0;
   logic               no_idle = 1'b0;

   positional_array_list #(.DEPTH(LIST_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic list_rsp_type apply_list_op(op_type op, logic [POS_W-1:0] pos,
                                                  logic [VALUE_W-1:0] val);
      list_rsp_type r;
      int           at;
      r.data_out = '0;
      r.status   = ST_OK;
      case (op)
         OP_INS_POS, OP_INS_FRONT, OP_INS_END: begin
            at = (op == OP_INS_POS) ? int'(pos) :
                 ((op == OP_INS_FRONT) ? 0 : int'(list_count));
            if (int'(list_count) >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else if (at > int'(list_count)) begin
               r.status = ST_RANGE;
            end else begin
               for (int i = int'(list_count); i > at; i--) list_store[i] = list_store[i-1];
               list_store[at] = val;
               list_count = list_count + COUNT_W'(1);
            end
         end
         OP_REM_POS, OP_REM_FRONT, OP_REM_END: begin
            if (list_count == 0) begin
               r.status = ST_RANGE;
            end else begin
               at = (op == OP_REM_POS) ? int'(pos) :
                    ((op == OP_REM_FRONT) ? 0 : int'(list_count) - 1);
               if (at >= int'(list_count)) begin
                  r.status = ST_RANGE;
               end else begin
                  r.data_out = list_store[at];
                  for (int i = at; i < int'(list_count) - 1; i++) list_store[i] = list_store[i+1];
                  list_count = list_count - COUNT_W'(1);
               end
            end
         end
         OP_READ: begin
            if (pos >= list_count) r.status = ST_RANGE;
            else r.data_out = list_store[pos];
         end
         default: begin
            if (pos >= list_count) r.status = ST_RANGE;
            else list_store[pos] = val;
         end
      endcase
      r.count    = list_count;
      r.is_empty = (list_count == 0);
      return r;
   endfunction

   // one word per call; valid stays high so back-to-back words need no toggle
   task automatic send_word(op_type op, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
      if (!no_idle) begin
         while ($urandom_range(99) < 32) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, val, pos};
      do @(posedge clock); while (!req_tready);
      pending_rsps.push_back(apply_list_op(op, pos, val));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic check_response();
      list_rsp_type exp_rsp;
      if (pending_rsps.size() == 0) begin
         $display("%0t: response word with none expected: tdata %h tuser %h",
                  $time, rsp_tdata, rsp_tuser);
         error_count++;
      end else begin
         exp_rsp = pending_rsps.pop_front();
         if (rsp_tdata[31:0] !== exp_rsp.data_out) begin
            $display("%0t: data_out expected %h actual %h", $time, exp_rsp.data_out,
                     rsp_tdata[31:0]);
            error_count++;
         end
         if (rsp_tuser[1:0] !== exp_rsp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                     rsp_tuser[1:0]);
            error_count++;
         end
         if (rsp_tdata[36:32] !== exp_rsp.count) begin
            $display("%0t: count expected %0d actual %0d", $time, exp_rsp.count,
                     rsp_tdata[36:32]);
            error_count++;
         end
         if (rsp_tuser[2] !== exp_rsp.is_empty) begin
            $display("%0t: is_empty expected %b actual %b", $time, exp_rsp.is_empty,
                     rsp_tuser[2]);
            error_count++;
         end
         if (rsp_tdata[39:37] !== 3'b000) begin
            $display("%0t: tdata pad expected %b actual %b", $time, 3'b000, rsp_tdata[39:37]);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_response();
      if (no_idle) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(99) >= 32);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, pending_rsps.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(19))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position(op_type op);
      if ($urandom_range(99) < 20) return POS_W'($urandom_range(LIST_DEPTH));
      if (op == OP_INS_POS) return POS_W'($urandom_range(int'(list_count)));
      if (list_count == 0) return '0;
      return POS_W'($urandom_range(int'(list_count) - 1));
   endfunction

   // lean: 0 insert heavy, 1 remove heavy, 2 even mix
   function automatic op_type pick_op(int lean);
      int roll;
      roll = $urandom_range(99);
      case (lean)
         0: begin
            if (roll < 70) return op_type'($urandom_range(2));
            if (roll < 85) return op_type'($urandom_range(5, 3));
         end
         1: begin
            if (roll < 70) return op_type'($urandom_range(5, 3));
            if (roll < 85) return op_type'($urandom_range(2));
         end
         default: return op_type'($urandom_range(7));
      endcase
      return op_type'($urandom_range(7, 6));
   endfunction

   task automatic test_empty_list();
      send_word(OP_REM_POS, 5'd0, 32'h0);
      send_word(OP_REM_FRONT, 5'd0, 32'h0);
      send_word(OP_REM_END, 5'd16, 32'h0);
      send_word(OP_READ, 5'd0, 32'h0);
      send_word(OP_WRITE, 5'd0, 32'h1234_5678);
   endtask

   task automatic test_basic_ops();
      send_word(OP_INS_END, 5'd0, 32'h7fff_ffff);
      send_word(OP_INS_FRONT, 5'd31, 32'h8000_0000);
      send_word(OP_INS_POS, 5'd1, 32'h0000_0000);
      send_word(OP_INS_POS, 5'd3, 32'hffff_ffff);
      send_word(OP_INS_POS, 5'd16, 32'h5a5a_5a5a);
      send_word(OP_INS_POS, 5'd5, 32'h5a5a_5a5a);
      for (int i = 0; i <= 4; i++) send_word(OP_READ, POS_W'(i), 32'h0);
      send_word(OP_WRITE, 5'd2, 32'ha5a5_a5a5);
      send_word(OP_WRITE, 5'd4, 32'h1111_1111);
      send_word(OP_READ, 5'd2, 32'h0);
      send_word(OP_REM_POS, 5'd1, 32'h0);
      send_word(OP_REM_POS, 5'd3, 32'h0);
      send_word(OP_REM_FRONT, 5'd0, 32'h0);
      send_word(OP_REM_END, 5'd0, 32'h0);
      send_word(OP_REM_POS, 5'd0, 32'h0);
      wait_drained();
   endtask

   task automatic test_full_list();
      op_type op;
      while (int'(list_count) < LIST_DEPTH) begin
         op = op_type'($urandom_range(2));
         send_word(op, POS_W'($urandom_range(int'(list_count))), pick_value());
      end
      send_word(OP_INS_POS, 5'd16, 32'h0bad_f00d);
      send_word(OP_INS_POS, 5'd0, 32'h0bad_f00d);
      send_word(OP_INS_FRONT, 5'd0, 32'h0bad_f00d);
      send_word(OP_INS_END, 5'd0, 32'h0bad_f00d);
      send_word(OP_READ, 5'd16, 32'h0);
      send_word(OP_WRITE, 5'd16, 32'h0);
      send_word(OP_WRITE, 5'd15, 32'h8000_0001);
      send_word(OP_READ, 5'd15, 32'h0);
      send_word(OP_REM_POS, 5'd15, 32'h0);
      send_word(OP_INS_POS, 5'd15, 32'h7fff_fffe);
      send_word(OP_REM_POS, 5'd0, 32'h0);
      while (list_count != 0) begin
         op = op_type'($urandom_range(5, 3));
         send_word(op, pick_position(op), 32'h0);
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      op_type op;
      for (int batch = 0; batch < 32; batch++) begin
         no_idle = (batch >= 8 && batch < 14);
         for (int n = 0; n < 50; n++) begin
            op = pick_op(batch % 3);
            send_word(op, pick_position(op), pick_value());
         end
         // hold off the sender until the block has answered everything
         if (batch == 20) wait_drained();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_basic_ops();
      test_full_list();
      test_random_traffic();
      wait_drained();
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
